// ===== rtl/tlc_pkg.sv =====
// Shared types and constants for the two-level cache tag model.
package tlc_pkg;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_RHIT  = 3'd1,
    ST_RMISS = 3'd2,
    ST_WHIT  = 3'd3,
    ST_WMISS = 3'd4
  } acc_state_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_L1_OFF  = 3'd0,
    REG_L1_IDX  = 3'd1,
    REG_L1_WAYS = 3'd2,
    REG_L2_OFF  = 3'd3,
    REG_L2_IDX  = 3'd4,
    REG_L2_WAYS = 3'd5
  } cfg_reg_e;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage

// ===== rtl/tlc_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface tlc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] address;
  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface tlc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] l1_state;
  logic [2:0] l2_state;
  modport source (output valid, output l1_state, output l2_state, input ready);
  modport sink   (input valid, input l1_state, input l2_state, output ready);
endinterface

// ===== rtl/tlc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module tlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/tlc_level.sv =====
// One cache level: set row in RAM, lookup, LRU update, row write back, clearing pass.
module tlc_level
  import tlc_pkg::*;
#(
  parameter int unsigned SetsMax = 256,
  parameter int unsigned WaysMax = 8,
  parameter int unsigned WaysRegW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [3:0]                  off_i,
  input  logic [3:0]                  ib_i,
  input  logic [WaysRegW-1:0]         ways_i,
  input  logic [31:0]                 addr_i,
  input  logic                        upd_i,     // write back row
  input  logic                        alloc_i,   // allocate on miss, else touch hit
  output logic                        busy_o,    // clearing pass running
  output logic                        hit_o
);
  localparam int unsigned SetW = (SetsMax > 1) ? $clog2(SetsMax) : 1;
  localparam int unsigned WayW = (WaysMax > 1) ? $clog2(WaysMax) : 1;
  localparam int unsigned IbMax = $clog2(SetsMax);
  localparam int unsigned RowW = WaysMax * (32 + 1 + WayW);

  typedef logic [WayW-1:0] way_t;

  // effective geometry
  logic [3:0]  ib_eff;
  logic [4:0]  ways_eff;
  logic [31:0] tag, set_full;
  logic [SetW-1:0] set_idx;

  always_comb begin
    ib_eff = (ib_i > 4'(IbMax)) ? 4'(IbMax) : ib_i;
    if (ways_i == '0) ways_eff = 5'd1;
    else if (32'(ways_i) > WaysMax) ways_eff = 5'(WaysMax);
    else ways_eff = 5'(ways_i);
    set_full = (addr_i >> off_i) & ((32'd1 << ib_eff) - 32'd1);
    set_idx  = set_full[SetW-1:0];
    tag      = 32'(({32'd0, addr_i} >> (6'(off_i) + 6'(ib_eff))));
  end

  // clearing pass
  logic [SetW:0] clr_q, clr_d;
  logic clearing;
  assign clearing = (clr_q != (SetW+1)'(SetsMax));
  assign busy_o = clearing;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else clr_q <= clr_d;
  end
  assign clr_d = clearing ? clr_q + 1'b1 : clr_q;

  logic [SetW-1:0] ram_addr;
  logic ram_we;
  logic [RowW-1:0] wrow, rrow;

  logic [31:0] tags  [WaysMax];
  logic        vld   [WaysMax];
  way_t        rec   [WaysMax];
  logic [31:0] ntags [WaysMax];
  logic        nvld  [WaysMax];
  way_t        nrec  [WaysMax];

  always_comb begin
    for (int w = 0; w < WaysMax; w++) begin
      tags[w] = rrow[w*(33+WayW) +: 32];
      vld[w]  = rrow[w*(33+WayW) + 32];
      rec[w]  = rrow[w*(33+WayW) + 33 +: WayW];
    end
  end

  // lookup
  logic hit;
  way_t hway;
  always_comb begin
    hit = 1'b0;
    hway = '0;
    for (int w = WaysMax-1; w >= 0; w--) begin
      if (5'(w) < ways_eff && vld[w] && tags[w] == tag) begin
        hit = 1'b1;
        hway = way_t'(w);
      end
    end
  end
  assign hit_o = hit;

  // victim
  logic inv_found, lru_found;
  way_t inv_way, lru_way, victim, tway;
  always_comb begin
    inv_found = 1'b0;
    inv_way = '0;
    for (int w = WaysMax-1; w >= 0; w--) begin
      if (5'(w) < ways_eff && !vld[w]) begin
        inv_found = 1'b1;
        inv_way = way_t'(w);
      end
    end
    lru_found = 1'b0;
    lru_way = '0;
    for (int p = 0; p < WaysMax; p++) begin
      if (5'(rec[p]) < ways_eff) begin
        lru_found = 1'b1;
        lru_way = rec[p];
      end
    end
    victim = inv_found ? inv_way : (lru_found ? lru_way : '0);
    tway = alloc_i ? victim : hway;
  end

  // move tway to front of recency list
  logic [WaysMax-1:0] before_hit;
  always_comb begin
    for (int w = 0; w < WaysMax; w++) begin
      ntags[w] = tags[w];
      nvld[w]  = vld[w];
    end
    if (alloc_i) begin
      ntags[tway] = tag;
      nvld[tway]  = 1'b1;
    end
    before_hit[0] = 1'b0;
    for (int p = 1; p < WaysMax; p++) begin
      before_hit[p] = before_hit[p-1] || (rec[p-1] == tway);
    end
    for (int p = 0; p < WaysMax; p++) begin
      if (p == 0) nrec[p] = tway;
      else if (!before_hit[p] && rec[p] != tway) nrec[p] = rec[p];
      else if (!before_hit[p]) nrec[p] = rec[p-1];
      else nrec[p] = rec[p];
    end
    // if tway was found, positions up to it shift by one
    for (int p = 1; p < WaysMax; p++) begin
      if (!before_hit[p]) nrec[p] = rec[p-1];
    end
    if (clearing) begin
      for (int w = 0; w < WaysMax; w++) begin
        ntags[w] = '0;
        nvld[w]  = 1'b0;
        nrec[w]  = way_t'(w);
      end
    end
    for (int w = 0; w < WaysMax; w++) begin
      wrow[w*(33+WayW) +: 32]        = ntags[w];
      wrow[w*(33+WayW) + 32]         = nvld[w];
      wrow[w*(33+WayW) + 33 +: WayW] = nrec[w];
    end
  end

  assign ram_we = clearing || upd_i;
  assign ram_addr = clearing ? clr_q[SetW-1:0] : set_idx;

  tlc_ram #(.Width(RowW), .Depth(SetsMax)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wrow),
    .rdata_o (rrow)
  );
endmodule

// ===== rtl/two_level_cache_hit_miss_lru.sv =====
// Top level of the two-level cache hit/miss and LRU tag model.
//
//  channel  dir  payload                 beat when
//  req      in   opcode, address         req.valid & req.ready
//  rsp      out  l1_state, l2_state      rsp.valid & rsp.ready
//  cfg      in   cfg_idx_i, cfg_data_i   cfg_we_i
//
// Both rows are read at the accept edge. An access that reaches L2 passes
// through S_L1 (L1 lookup and update), S_L2RD (L2 row re-read), S_L2 (L2
// update) and S_OUT (result register); an L1 read hit goes from S_L1 straight
// to S_OUT. The single RAM port per level sets this; the block returns to
// S_IDLE after each result beat before the next accept. After reset a
// clearing pass over every set of both levels runs with req.ready low. A
// result waits in its register; the next request is taken once it is gone.
module two_level_cache_hit_miss_lru
  import tlc_pkg::*;
#(
  parameter int unsigned L1_SETS_MAX = 256,
  parameter int unsigned L1_WAYS_MAX = 8,
  parameter int unsigned L2_SETS_MAX = 1024,
  parameter int unsigned L2_WAYS_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tlc_req_if.sink             req,
  tlc_rsp_if.source           rsp
);
  typedef enum logic [2:0] {S_IDLE, S_L1, S_L2RD, S_L2, S_OUT} st_e;

  logic [3:0] l1_off_q, l1_ib_q, l1_ways_q, l2_off_q, l2_ib_q;
  logic [4:0] l2_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_off_q <= 4'd2; l1_ib_q <= 4'd6; l1_ways_q <= 4'd4;
      l2_off_q <= 4'd2; l2_ib_q <= 4'd8; l2_ways_q <= 5'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_L1_OFF:  l1_off_q  <= cfg_data_i[3:0];
        REG_L1_IDX:  l1_ib_q   <= cfg_data_i[3:0];
        REG_L1_WAYS: l1_ways_q <= cfg_data_i[3:0];
        REG_L2_OFF:  l2_off_q  <= cfg_data_i[3:0];
        REG_L2_IDX:  l2_ib_q   <= cfg_data_i[3:0];
        REG_L2_WAYS: l2_ways_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  st_e st_q;
  logic wr_q;
  logic [31:0] addr_q;
  logic h1_q;
  acc_state_e s1_q, s2_q;
  logic b1, b2, h1, h2;
  logic l1_upd, l1_alloc, l2_upd, l2_alloc;

  // request address is held in addr_q for the whole access; rows are read
  // at the accept edge straight from the incoming address.
  logic [31:0] addr_use;
  assign addr_use = (st_q == S_IDLE) ? req.address : addr_q;

  assign req.ready = (st_q == S_IDLE) && !b1 && !b2;
  assign rsp.valid = (st_q == S_OUT);
  assign rsp.l1_state = s1_q;
  assign rsp.l2_state = s2_q;

  // L1 update in S_L1: read hit touches, read miss allocates, write hit touches
  assign l1_upd   = (st_q == S_L1) && (h1 || !wr_q);
  assign l1_alloc = !h1;
  // L2 update in S_L2: on read (after L1 miss) hit touches/miss allocates;
  // on write only a hit touches
  assign l2_upd   = (st_q == S_L2) && (h2 || !wr_q);
  assign l2_alloc = !h2;

  tlc_level #(.SetsMax(L1_SETS_MAX), .WaysMax(L1_WAYS_MAX), .WaysRegW(4)) u_l1 (
    .clk_i, .rst_ni,
    .off_i (l1_off_q), .ib_i (l1_ib_q), .ways_i (l1_ways_q),
    .addr_i (addr_use),
    .upd_i (l1_upd), .alloc_i (l1_alloc),
    .busy_o (b1), .hit_o (h1)
  );

  tlc_level #(.SetsMax(L2_SETS_MAX), .WaysMax(L2_WAYS_MAX), .WaysRegW(5)) u_l2 (
    .clk_i, .rst_ni,
    .off_i (l2_off_q), .ib_i (l2_ib_q), .ways_i (l2_ways_q),
    .addr_i (addr_use),
    .upd_i (l2_upd), .alloc_i (l2_alloc),
    .busy_o (b2), .hit_o (h2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      wr_q <= 1'b0;
      h1_q <= 1'b0;
      s1_q <= ST_NONE;
      s2_q <= ST_NONE;
      addr_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (req.valid && req.ready) begin
          wr_q   <= req.opcode;
          addr_q <= req.address;
          st_q   <= S_L1;
        end
        S_L1: begin
          h1_q <= h1;
          if (!wr_q && h1) begin
            s1_q <= ST_RHIT; s2_q <= ST_NONE; st_q <= S_OUT;
          end else begin
            st_q <= S_L2RD;
          end
        end
        S_L2RD: st_q <= S_L2;
        S_L2: begin
          if (!wr_q) begin
            s1_q <= ST_RMISS; s2_q <= h2 ? ST_RHIT : ST_RMISS;
          end else if (h1_q) begin
            s1_q <= ST_WHIT; s2_q <= ST_WHIT;
          end else begin
            s1_q <= ST_WMISS; s2_q <= h2 ? ST_WHIT : ST_WMISS;
          end
          st_q <= S_OUT;
        end
        S_OUT: if (rsp.ready) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !req.ready) else $error("accept while busy");
  a_rhit_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.l1_state == ST_RHIT) |-> (rsp.l2_state == ST_NONE))
    else $error("L1 read hit must skip L2");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1 || b2) |-> !req.ready) else $error("accept during clearing");
`endif
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the two-level cache hit/miss and LRU tag model.
module tb_top;
  import tlc_pkg::*;

  localparam int unsigned L1Sets = 256;
  localparam int unsigned L1Ways = 8;
  localparam int unsigned L2Sets = 1024;
  localparam int unsigned L2Ways = 16;

  typedef struct packed {
    acc_state_e l1;
    acc_state_e l2;
  } access_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tlc_req_if req_ch ();
  tlc_rsp_if rsp_ch ();

  two_level_cache_hit_miss_lru dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of both tag arrays. Index 0 is L1, index 1 is L2; L1 uses
  // only the low corner of each dimension.
  logic [31:0] shadow_tag [2][L2Sets][L2Ways];
  bit          shadow_vld [2][L2Sets][L2Ways];
  int unsigned shadow_rec [2][L2Sets][L2Ways];
  int unsigned sets_max [2];
  int unsigned ways_max [2];

  // Register values as written, and the geometry they resolve to.
  logic [4:0]  reg_val [6];
  int unsigned eff_off [2];
  int unsigned eff_ib [2];
  int unsigned eff_ways [2];

  access_result_t pending_results [$];
  int unsigned    errors;
  bit             no_idle;  // when set both sides run back to back

  // Resolve the register file into per-level geometry (saturating).
  function automatic void resolve_geometry();
    int unsigned lvl, m, ib, wy;
    for (lvl = 0; lvl < 2; lvl++) begin
      eff_off[lvl] = reg_val[lvl*3 + 0] & 15;
      ib = reg_val[lvl*3 + 1] & 15;
      wy = (lvl == 0) ? (reg_val[2] & 15) : (reg_val[5] & 31);
      m = 0;
      while (m < ib && (1 << (m + 1)) <= sets_max[lvl]) m++;
      eff_ib[lvl] = m;
      if (wy == 0) wy = 1;
      if (wy > ways_max[lvl]) wy = ways_max[lvl];
      eff_ways[lvl] = wy;
    end
  endfunction

  function automatic void reset_shadow();
    int unsigned lvl, s, w;
    sets_max[0] = L1Sets;
    ways_max[0] = L1Ways;
    sets_max[1] = L2Sets;
    ways_max[1] = L2Ways;
    for (lvl = 0; lvl < 2; lvl++)
      for (s = 0; s < L2Sets; s++)
        for (w = 0; w < L2Ways; w++) begin
          shadow_vld[lvl][s][w] = 1'b0;
          shadow_rec[lvl][s][w] = w;
        end
    reg_val[REG_L1_OFF]  = 5'd2;
    reg_val[REG_L1_IDX]  = 5'd6;
    reg_val[REG_L1_WAYS] = 5'd4;
    reg_val[REG_L2_OFF]  = 5'd2;
    reg_val[REG_L2_IDX]  = 5'd8;
    reg_val[REG_L2_WAYS] = 5'd8;
    resolve_geometry();
  endfunction

  function automatic int unsigned set_of(int unsigned lvl, logic [31:0] addr);
    return (addr >> eff_off[lvl]) & ((32'd1 << eff_ib[lvl]) - 1);
  endfunction

  function automatic logic [31:0] tag_of(int unsigned lvl, logic [31:0] addr);
    return addr >> (eff_off[lvl] + eff_ib[lvl]);
  endfunction

  function automatic int find_way(int unsigned lvl, int unsigned s, logic [31:0] t);
    int unsigned w;
    for (w = 0; w < eff_ways[lvl]; w++)
      if (shadow_vld[lvl][s][w] && shadow_tag[lvl][s][w] == t) return w;
    return -1;
  endfunction

  // Move a way to the head of its set's recency list.
  function automatic void make_mru(int unsigned lvl, int unsigned s, int unsigned way);
    int unsigned p;
    p = 0;
    while (p < ways_max[lvl] && shadow_rec[lvl][s][p] != way) p++;
    if (p >= ways_max[lvl]) return;
    for (; p > 0; p--) shadow_rec[lvl][s][p] = shadow_rec[lvl][s][p-1];
    shadow_rec[lvl][s][0] = way;
  endfunction

  // Fill: first invalid way in use, else the oldest list entry that is in use.
  function automatic void fill_line(int unsigned lvl, int unsigned s, logic [31:0] t);
    int unsigned w, victim;
    int p;
    bit found;
    victim = 0;
    found = 1'b0;
    for (w = 0; w < eff_ways[lvl] && !found; w++)
      if (!shadow_vld[lvl][s][w]) begin
        victim = w;
        found = 1'b1;
      end
    for (p = ways_max[lvl] - 1; p >= 0 && !found; p--)
      if (shadow_rec[lvl][s][p] < eff_ways[lvl]) begin
        victim = shadow_rec[lvl][s][p];
        found = 1'b1;
      end
    shadow_tag[lvl][s][victim] = t;
    shadow_vld[lvl][s][victim] = 1'b1;
    make_mru(lvl, s, victim);
  endfunction

  function automatic access_result_t predict_access(logic op, logic [31:0] addr);
    access_result_t r;
    int unsigned s1, s2;
    logic [31:0] t1, t2;
    int h1, h2;
    s1 = set_of(0, addr);
    s2 = set_of(1, addr);
    t1 = tag_of(0, addr);
    t2 = tag_of(1, addr);
    h1 = find_way(0, s1, t1);
    h2 = find_way(1, s2, t2);
    if (op == OP_READ) begin
      if (h1 >= 0) begin
        make_mru(0, s1, h1);
        r.l1 = ST_RHIT;
        r.l2 = ST_NONE;  // L2 untouched on an L1 read hit
      end else begin
        r.l1 = ST_RMISS;
        if (h2 < 0) begin
          r.l2 = ST_RMISS;
          fill_line(1, s2, t2);
        end else begin
          r.l2 = ST_RHIT;
          make_mru(1, s2, h2);
        end
        fill_line(0, s1, t1);
      end
    end else begin
      if (h1 >= 0) begin
        // L1 write hit reports L2 hit even if L2 dropped the line
        make_mru(0, s1, h1);
        if (h2 >= 0) make_mru(1, s2, h2);
        r.l1 = ST_WHIT;
        r.l2 = ST_WHIT;
      end else if (h2 >= 0) begin
        make_mru(1, s2, h2);
        r.l1 = ST_WMISS;
        r.l2 = ST_WHIT;
      end else begin
        r.l1 = ST_WMISS;
        r.l2 = ST_WMISS;
      end
    end
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Send one access beat; valid stays high into a back-to-back beat.
  task automatic send_access(logic op, logic [31:0] addr);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_results.push_back(predict_access(op, addr));
  endtask

  // Lower valid and wait for every outstanding result plus pipeline slack.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write all six registers back to back once the block has gone idle.
  task automatic program_regs(logic [4:0] v [6]);
    int i;
    drain();
    for (i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      reg_val[i] = v[i];
    end
    cfg_we_i <= 1'b0;
    resolve_geometry();
    @(posedge clk_i);
  endtask

  // Pool of hot addresses so that hits and evictions are common.
  logic [31:0] hot_addr [32];

  task automatic refill_pool();
    int i;
    logic [31:0] base;
    base = $urandom();
    for (i = 0; i < 32; i++)
      hot_addr[i] = (i < 8) ? $urandom() : base ^ ($urandom() & 32'h0003_0ffc);
  endtask

  function automatic logic [31:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return $urandom();
    if (sel < 25) return hot_addr[$urandom_range(0, 31)] ^ $urandom_range(0, 4095);
    return hot_addr[$urandom_range(0, 31)];
  endfunction

  task automatic random_burst(int unsigned n);
    int unsigned i;
    logic op;
    refill_pool();
    for (i = 0; i < n; i++) begin
      no_idle = (i % 60) >= 45;  // some stretches run at full rate
      op = ($urandom_range(0, 99) < 65) ? OP_READ : OP_WRITE;
      send_access(op, pick_addr());
    end
    no_idle = 1'b0;
  endtask

  // Directed: fill, hit, write hit/miss, address extremes at reset geometry.
  task automatic test_directed_defaults();
    send_access(OP_READ,  32'h0000_0000);
    send_access(OP_READ,  32'h0000_0000);
    send_access(OP_WRITE, 32'h0000_0000);
    send_access(OP_WRITE, 32'hffff_ffff);
    send_access(OP_READ,  32'hffff_ffff);
    send_access(OP_WRITE, 32'hffff_fffc);
    send_access(OP_READ,  32'h0000_0100);
    send_access(OP_READ,  32'h0001_0100);
    send_access(OP_READ,  32'h0002_0100);
    send_access(OP_READ,  32'h0003_0100);
    send_access(OP_READ,  32'h0004_0100);  // evicts LRU way in L1 set
    send_access(OP_READ,  32'h0000_0100);  // L1 miss, L2 hit
    send_access(OP_WRITE, 32'h0005_0100);
    send_access(OP_WRITE, 32'h0004_0100);
    send_access(OP_READ,  32'haaaa_aaaa);
    send_access(OP_READ,  32'h5555_5555);
    drain();
  endtask

  // Tiny L1 and L2 (one line each): fill, replace and write hits, then a random burst.
  task automatic test_tiny_l2();
    logic [4:0] v [6];
    v = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
    program_regs(v);
    send_access(OP_READ,  32'h0000_1000);
    send_access(OP_READ,  32'h0000_2000);
    send_access(OP_WRITE, 32'h0000_2000);
    send_access(OP_READ,  32'h0000_1000);
    send_access(OP_WRITE, 32'h0000_1000);
    random_burst(150);
    drain();
  endtask

  // Every register at its top code: saturating ways and index, large offsets.
  task automatic test_saturation();
    logic [4:0] v [6];
    v = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};
    program_regs(v);
    random_burst(150);
    v = '{5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd17};
    program_regs(v);
    random_burst(80);
    drain();
  endtask

  // Full-size legal geometry, with a hold-off until every result is back.
  task automatic test_max_legal();
    logic [4:0] v [6];
    v = '{5'd12, 5'd8, 5'd8, 5'd12, 5'd10, 5'd16};
    program_regs(v);
    random_burst(80);
    drain();
    random_burst(80);
    drain();
  endtask

  // Fully associative at both levels, all ways in use.
  task automatic test_fully_assoc();
    logic [4:0] v [6];
    v = '{5'd2, 5'd0, 5'd8, 5'd2, 5'd0, 5'd16};
    program_regs(v);
    random_burst(150);
    drain();
  endtask

  // Small mixed geometry, then reconfigure with lines left in place.
  task automatic test_mixed_reconfig();
    logic [4:0] v [6];
    v = '{5'd3, 5'd2, 5'd2, 5'd4, 5'd3, 5'd3};
    program_regs(v);
    random_burst(150);
    drain();
    v = '{5'd3, 5'd2, 5'd5, 5'd4, 5'd3, 5'd1};
    program_regs(v);
    random_burst(150);
    drain();
  endtask

  // Result side: random backpressure, then compare against the oldest prediction.
  initial begin : result_checker
    int unsigned stall;
    access_result_t exp_r;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: l1=%0d l2=%0d", $time,
                 rsp_ch.l1_state, rsp_ch.l2_state);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.l1_state !== exp_r.l1) begin
          $display("%0t: l1_state mismatch: expected %0d actual %0d", $time,
                   exp_r.l1, rsp_ch.l1_state);
          errors++;
        end
        if (rsp_ch.l2_state !== exp_r.l2) begin
          $display("%0t: l2_state mismatch: expected %0d actual %0d", $time,
                   exp_r.l2, rsp_ch.l2_state);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_seq
    errors = 0;
    no_idle = 1'b0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_L1_OFF;
    cfg_data_i     <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.opcode  <= OP_READ;
    req_ch.address <= '0;
    reset_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass: block holds ready low until its arrays are reset
    do @(posedge clk_i); while (!req_ch.ready);
    test_directed_defaults();
    random_burst(100);
    drain();
    test_tiny_l2();
    test_saturation();
    test_max_legal();
    test_fully_assoc();
    test_mixed_reconfig();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
